// ----- hw/rtl/pwc_pkg.sv -----
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared constants and types for the page-walk cache.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int DEF_SETS = 16;
  localparam int DEF_WAYS = 4;

  localparam int PART_W = 9;
  localparam int KEY_W  = 3 * PART_W;
  localparam int BASE_W = 48;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              leaf;
    logic [KEY_W-1:0]  key;
    logic [BASE_W-1:0] base;
  } pwc_way_t;

  localparam int WAY_W = $bits(pwc_way_t);

endpackage

// ----- hw/rtl/pwc_ram.sv -----
// ----------------------------------------------------------------------------
// pwc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/page_walk_cache_lru.sv -----
// ----------------------------------------------------------------------------
// page_walk_cache_lru
// Set-associative page-walk cache with true LRU replacement. One RAM row per
// set holds all ways (valid, mode, key, base) and their LRU ages.
//   A lookup result is registered in the compare state, after the set read;
//   an output stall on a pending result holds the compare state. Each item
//   gets a set read, then compare and write back through the single RAM;
//   the next item is taken in the write cycle. Reset: synchronous; a clearing
//   pass zeroes every row, during which no input is taken. leaf_mode resets to 0.
// ----------------------------------------------------------------------------
module page_walk_cache_lru #(
  parameter int SETS = pwc_pkg::DEF_SETS,
  parameter int WAYS = pwc_pkg::DEF_WAYS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [pwc_pkg::PART_W-1:0] in_index_top,
  input  logic [pwc_pkg::PART_W-1:0] in_index_mid,
  input  logic [pwc_pkg::PART_W-1:0] in_index_low,
  input  logic [pwc_pkg::BASE_W-1:0] in_table_base_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [pwc_pkg::BASE_W-1:0] out_table_base_out
);

  localparam int SW      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int AW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int PW      = pwc_pkg::PART_W;
  localparam int RSH     = 20;
  localparam int RECIP   = ((1 << RSH) + SETS - 1) / SETS;
  localparam int RECIP_W = RSH + 1;
  localparam int ROW_W   = WAYS * (pwc_pkg::WAY_W + AW);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_CMP  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [SW-1:0]              clr_cnt_r;
  logic                       leaf_mode_r;
  logic                       act_r;
  logic                       leaf_r;
  logic [pwc_pkg::KEY_W-1:0]  key_r;
  logic [pwc_pkg::BASE_W-1:0] base_r;
  logic [PW-1:0]              hash_r;
  logic [PW-1:0]              quot_r;
  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [pwc_pkg::BASE_W-1:0] out_base_r;

  logic [PW-1:0]              low_eff;
  logic [PW-1:0]              hash_c;
  logic [PW+RECIP_W-1:0]      quot_prod;
  logic [PW+SW+1:0]           quot_mul;
  logic [PW+SW+1:0]           rem_full;
  logic [SW-1:0]              set_c;

  logic                       in_xfer;
  logic                       cmp_done;
  logic                       cmp_fire;

  logic                       ram_we, ram_re;
  logic [SW-1:0]              ram_waddr;
  logic [ROW_W-1:0]           ram_wdata, ram_rdata;

  pwc_pkg::pwc_way_t [WAYS-1:0] row_ways, new_ways;
  logic [WAYS-1:0][AW-1:0]      row_ages, new_ages;
  logic [WAYS-1:0]              match;
  logic                         found_any, free_any;
  logic [AW-1:0]                found_idx, free_idx, victim_idx, tgt_idx;
  logic [AW:0]                  old_age;

  // key and set decode
  assign low_eff   = leaf_mode_r ? in_index_low : '0;
  assign hash_c    = in_index_top ^ in_index_mid ^ low_eff;
  assign quot_prod = (PW+RECIP_W)'(hash_c) * (PW+RECIP_W)'(RECIP);
  assign quot_mul  = (PW+SW+2)'(quot_r) * (PW+SW+2)'(SETS);
  assign rem_full  = (PW+SW+2)'(hash_r) - quot_mul;
  assign set_c     = rem_full[SW-1:0];

  assign cmp_done = !(act_r == pwc_pkg::ACT_LOOKUP && out_valid_r && out_stall);
  assign cmp_fire = (state_r == ST_CMP) && cmp_done;
  assign in_stall = !((state_r == ST_IDLE) || cmp_fire);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (clr_cnt_r == SW'(SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (cmp_done) state_nxt = in_valid ? ST_RD : ST_IDLE;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      leaf_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_cnt_r <= clr_cnt_r + SW'(1);
      if (cfg_wr_en) leaf_mode_r <= cfg_wr_data;
      out_valid_r <= (out_valid_r && out_stall) ||
                     (cmp_fire && act_r == pwc_pkg::ACT_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r  <= in_action;
      leaf_r <= leaf_mode_r;
      key_r  <= {low_eff, in_index_mid, in_index_top};
      base_r <= in_table_base_in;
      hash_r <= hash_c;
      quot_r <= quot_prod[RSH+PW-1:RSH];
    end
    if (cmp_fire && act_r == pwc_pkg::ACT_LOOKUP) begin
      out_hit_r  <= found_any;
      out_base_r <= found_any ? row_ways[found_idx].base : '0;
    end
  end

  // compare, choose way, age update
  assign {row_ages, row_ways} = ram_rdata;

  always_comb begin
    found_any  = 1'b0;
    found_idx  = '0;
    free_any   = 1'b0;
    free_idx   = '0;
    victim_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = row_ways[w].valid && (row_ways[w].leaf == leaf_r) &&
                 (row_ways[w].key == key_r);
      if (match[w]) begin
        found_any = 1'b1;
        found_idx = AW'(w);
      end
      if (!row_ways[w].valid) begin
        free_any = 1'b1;
        free_idx = AW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (row_ages[w] == AW'(WAYS - 1)) victim_idx = AW'(w);
    end

    if (found_any) begin
      tgt_idx = found_idx;
      old_age = {1'b0, row_ages[found_idx]};
    end else if (free_any) begin
      tgt_idx = free_idx;
      old_age = (AW+1)'(WAYS);
    end else begin
      tgt_idx = victim_idx;
      old_age = (AW+1)'(WAYS - 1);
    end

    new_ways = row_ways;
    new_ages = row_ages;
    for (int w = 0; w < WAYS; w++) begin
      if (AW'(w) != tgt_idx && row_ways[w].valid && {1'b0, row_ages[w]} < old_age) begin
        new_ages[w] = row_ages[w] + AW'(1);
      end
    end
    new_ages[tgt_idx] = '0;
    if (act_r == pwc_pkg::ACT_INSERT) begin
      new_ways[tgt_idx].valid = 1'b1;
      new_ways[tgt_idx].leaf  = leaf_r;
      new_ways[tgt_idx].key   = key_r;
      new_ways[tgt_idx].base  = base_r;
    end
  end

  assign ram_re    = (state_r == ST_RD);
  assign ram_we    = (state_r == ST_CLR) ||
                     (cmp_fire && (act_r == pwc_pkg::ACT_INSERT || found_any));
  assign ram_waddr = (state_r == ST_CLR) ? clr_cnt_r : set_c;
  assign ram_wdata = (state_r == ST_CLR) ? '0 : {new_ages, new_ways};

  pwc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .AW    (SW)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (set_c),
    .rdata (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_table_base_out = out_base_r;

  // checks
  a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> in_stall)
    else $error("input taken during clearing pass");

  a_out_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_CMP))
    else $error("result raised outside compare cycle");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLR || state_r == ST_CMP))
    else $error("row write outside clear or compare");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> $onehot0(match))
    else $error("key present in more than one way");

endmodule
